### hdl/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg
// Shared types and constants for the sorted character list.
// ----------------------------------------------------------------------------
package scl_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int VAL_W        = 8;
  localparam int OUT_CNT_W    = 6;
  localparam int STATUS_W     = 3;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic                    do_ins;  // insert is taken this cycle
    logic                    do_del;  // delete is taken this cycle
    logic signed [VAL_W-1:0] value;
  } bcast_t;

endpackage

### hdl/scl_cell.sv
// ----------------------------------------------------------------------------
// scl_cell
// One slot of the sorted list: compares, holds or shifts its entry.
// ----------------------------------------------------------------------------
module scl_cell #(
  parameter int CNT_W = 6,
  parameter int IDX   = 0
) (
  input  logic                                clk,
  input  scl_pkg::bcast_t                     bc,
  input  logic [CNT_W-1:0]                    cnt,
  input  logic                                left_gt,
  input  logic signed [scl_pkg::VAL_W-1:0]    left_val,
  input  logic signed [scl_pkg::VAL_W-1:0]    right_val,
  output logic                                gt,
  output logic                                hit,
  output logic signed [scl_pkg::VAL_W-1:0]    val,
  output logic signed [scl_pkg::VAL_W-1:0]    nxt
);

  logic occ;
  logic at_pos;

  assign occ    = CNT_W'(IDX) < cnt;
  // entries ahead of the search point are strictly below value
  assign gt     = occ && (bc.value > val);
  assign at_pos = !gt && left_gt;
  // first equal entry sits exactly at the search point
  assign hit    = at_pos && occ && (val == bc.value);

  always_comb begin
    nxt = val;
    if (bc.do_ins) begin
      if (at_pos) begin
        nxt = bc.value;
      end else if (!left_gt) begin
        nxt = left_val;
      end
    end else if (bc.do_del) begin
      if (!gt) begin
        nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val <= nxt;
  end

endmodule

### hdl/sorted_char_list_core.sv
// ----------------------------------------------------------------------------
// sorted_char_list_core
// Ascending list of signed 8-bit values with insert and delete.
// ----------------------------------------------------------------------------
//  channel | handshake            | words
//  --------+----------------------+------------------------------
//  in      | in_valid / in_stall  | action, value
//  out     | out_valid / out_stall| status, count, head_value
//
//  One word in, one word out: the row of cells compares every entry
//  with the broadcast value in parallel and each cell shifts in one step,
//  so a new word is taken every cycle while in_stall is low.
//  out_valid rises in the cycle after acceptance (output register).
//  A synchronous reset empties the list; cell contents are never cleared.
//  in_stall is raised only while a result waits and out_stall is high.
// ----------------------------------------------------------------------------
module sorted_char_list_core #(
  parameter int CAPACITY = scl_pkg::CAPACITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  action,
  input  logic signed [scl_pkg::VAL_W-1:0]      value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [scl_pkg::STATUS_W-1:0]          status,
  output logic [scl_pkg::OUT_CNT_W-1:0]         count,
  output logic signed [scl_pkg::VAL_W-1:0]      head_value
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // list length
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;

  // cell row wiring; gt and val carry a virtual left neighbor at index 0
  logic                              gt_w   [CAPACITY+1];
  logic signed [scl_pkg::VAL_W-1:0]  val_w  [CAPACITY+1];
  logic signed [scl_pkg::VAL_W-1:0]  nxt_w  [CAPACITY];
  logic [CAPACITY-1:0]               hit_w;

  scl_pkg::bcast_t       bc;
  scl_pkg::status_t      st_next;
  logic                  in_acc;
  logic                  full;
  logic                  found;
  logic [CNT_W+scl_pkg::OUT_CNT_W-1:0] cnt_ext;

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign full     = cnt >= CNT_W'(CAPACITY);
  assign found    = |hit_w;

  assign bc.value  = value;
  assign bc.do_ins = in_acc && (action == scl_pkg::ACT_INSERT) && !full;
  assign bc.do_del = in_acc && (action == scl_pkg::ACT_DELETE) && found;

  // left of slot 0 everything is "less": the search point can start there
  assign gt_w[0]  = 1'b1;
  assign val_w[0] = value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [scl_pkg::VAL_W-1:0] rv;
    // the last slot pulls its own entry; it falls out of range on delete
    if (i == CAPACITY - 1) begin : g_last
      assign rv = val_w[i+1];
    end else begin : g_mid
      assign rv = val_w[i+2];
    end
    scl_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .bc        (bc),
      .cnt       (cnt),
      .left_gt   (gt_w[i]),
      .left_val  (val_w[i]),
      .right_val (rv),
      .gt        (gt_w[i+1]),
      .hit       (hit_w[i]),
      .val       (val_w[i+1]),
      .nxt       (nxt_w[i])
    );
  end

  // status and length update
  always_comb begin
    cnt_next = cnt;
    st_next  = scl_pkg::ST_INSERTED;
    if (action == scl_pkg::ACT_INSERT) begin
      if (full) begin
        st_next = scl_pkg::ST_FULL;
      end else begin
        st_next  = scl_pkg::ST_INSERTED;
        cnt_next = cnt + CNT_W'(1);
      end
    end else begin
      if (cnt == '0) begin
        st_next = scl_pkg::ST_EMPTY;
      end else if (found) begin
        st_next  = scl_pkg::ST_DELETED;
        cnt_next = cnt - CNT_W'(1);
      end else begin
        st_next = scl_pkg::ST_NOT_FOUND;
      end
    end
  end

  // reported count is the low bits of the length
  assign cnt_ext = {{scl_pkg::OUT_CNT_W{1'b0}}, cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status     <= st_next;
      count      <= cnt_ext[scl_pkg::OUT_CNT_W-1:0];
      head_value <= (cnt_next == '0) ? '0 : nxt_w[0];
    end
  end

  a_cap : assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("list length above capacity");

  a_ins : assert property (@(posedge clk) disable iff (rst)
    in_acc && (action == scl_pkg::ACT_INSERT) && !full
    |=> cnt == $past(cnt) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_del_miss : assert property (@(posedge clk) disable iff (rst)
    in_acc && (action == scl_pkg::ACT_DELETE) && !found |=> $stable(cnt))
    else $error("missed delete changed the length");

  a_empty_head : assert property (@(posedge clk) disable iff (rst)
    out_valid && (cnt == '0) |-> head_value == '0)
    else $error("empty list reports a nonzero head");

endmodule
